[hdl/dense_graph_shortest_path_top_macros.svh]
// Assertion macros shared by the shortest-path block.
`ifndef DENSE_GRAPH_SHORTEST_PATH_TOP_MACROS_SVH
`define DENSE_GRAPH_SHORTEST_PATH_TOP_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define DGSP_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be seen out of reset.
`define DGSP_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[hdl/dgsp_pkg.sv]
// Shared types and constants of the shortest-path block.
package dgsp_pkg;

	localparam int COST_W = 24;
	localparam int NODE_FIELD_W = 5;
	localparam int MAX_OUT = 32;
	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	typedef logic [COST_W-1:0] cost_t;
	typedef logic [NODE_FIELD_W-1:0] node_field_t;

endpackage

[hdl/dgsp_edge_mem.sv]
// Adjacency matrix store with a clearing sweep after reset.
`include "dense_graph_shortest_path_top_macros.svh"

module dgsp_edge_mem #(
	parameter int NODES = 32,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [$clog2(NODES*NODES)-1:0] waddr,
	input  logic                          won,
	input  logic [WEIGHT_BITS-1:0]        ww,
	input  logic [$clog2(NODES*NODES)-1:0] raddr,
	output logic                          ron,
	output logic [WEIGHT_BITS-1:0]        rw,
	output logic                          clearing
);

	localparam int NN = NODES * NODES;
	localparam int AW = $clog2(NN);
	localparam int CW = $clog2(NN + 1);

	logic [WEIGHT_BITS:0] mem [NN];
	logic [WEIGHT_BITS:0] rd_q;
	logic [CW-1:0]        clr_q;

	assign clearing = clr_q < CW'(NN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + CW'(1);
		end
	end

	// Sweep one entry a cycle to mark every edge absent.
	always_ff @(posedge clk) begin
		if (clearing) begin
			mem[clr_q[AW-1:0]] <= '0;
		end else if (we) begin
			mem[waddr] <= {won, ww};
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[raddr];
	end

	assign ron = rd_q[WEIGHT_BITS];
	assign rw  = rd_q[WEIGHT_BITS-1:0];

	`DGSP_NEVER(a_no_wr_clear, clearing && we, "edge write during clearing sweep")
	`DGSP_CHECK(a_clr_end, $fell(clearing) |-> clr_q == CW'(NN), "sweep ended early")
	`DGSP_CHECK(a_clr_once, !clearing |=> !clearing, "sweep restarted without reset")

endmodule

[hdl/dgsp_relax_unit.sv]
// Shared saturating adder and cost comparator.
module dgsp_relax_unit #(
	parameter int WEIGHT_BITS = 16
) (
	input  dgsp_pkg::cost_t         base,
	input  logic [WEIGHT_BITS-1:0]  w,
	input  dgsp_pkg::cost_t         ref_c,
	input  logic                    tie_lt,
	output dgsp_pkg::cost_t         sum,
	output logic                    lt
);

	import dgsp_pkg::*;

	localparam int SUM_W = ((WEIGHT_BITS > COST_W) ? WEIGHT_BITS : COST_W) + 1;

	logic [SUM_W-1:0] raw;

	assign raw = SUM_W'(base) + SUM_W'(w);
	assign sum = (raw > SUM_W'(COST_MAX)) ? COST_MAX : raw[COST_W-1:0];
	assign lt  = (sum < ref_c) || ((sum == ref_c) && tie_lt);

endmodule

[hdl/dense_graph_shortest_path_top.sv]
// Dense-graph shortest path engine: edge store, sequencer and node tables.
// An edge write is taken while idle. A query relaxes the row of each settled node, runs the
// cheapest-cycle scan when source equals destination, walks the path chain and emits the results.
// Rate is set by the shared relax unit, which takes one matrix entry per cycle.
// After reset the edge store clears one entry a cycle, busy held high.
// Results are strobed for one cycle each; the receiver cannot hold them off.
`include "dense_graph_shortest_path_top_macros.svh"

module dense_graph_shortest_path_top #(
	parameter int NODES = 32,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  action,
	input  dgsp_pkg::node_field_t src_node,
	input  dgsp_pkg::node_field_t dst_node,
	input  logic [15:0]           edge_weight,
	input  logic                  edge_present,
	output logic                  strobe,
	output dgsp_pkg::node_field_t path_node,
	output dgsp_pkg::cost_t       path_cost,
	output logic                  found,
	output logic                  last
);

	import dgsp_pkg::*;

	localparam int NW = $clog2(NODES);
	localparam int AW = $clog2(NODES * NODES);
	localparam int KW = $clog2(NODES + 1);

	typedef enum logic [11:0] {
		S_IDLE     = 12'b000000000001,
		S_INIT     = 12'b000000000010,
		S_RELAX    = 12'b000000000100,
		S_PICK     = 12'b000000001000,
		S_CYC      = 12'b000000010000,
		S_CYC_END  = 12'b000000100000,
		S_WALK     = 12'b000001000000,
		S_WALK_RD  = 12'b000010000000,
		S_EMIT     = 12'b000100000000,
		S_EMIT_RD  = 12'b001000000000,
		S_EMIT_OUT = 12'b010000000000,
		S_NF       = 12'b100000000000
	} state_t;

	state_t st_q;

	logic [NW-1:0] src_q, dst_q, cur_q, v_q, v_s1, node_q, bv_q, bp_q, nd_q;
	logic          cyc_q, iss_done_q, valid_s1, have_q;
	cost_t         cur_cost_q, bc_q, final_q;
	logic [NODES-1:0] done_q, tval_q;
	logic [KW-1:0] k_q, km1;
	logic [4:0]    n_q;

	// node tables
	cost_t         cost_mem [NODES];
	logic [NW-1:0] pred_mem [NODES];
	logic [NW-1:0] chain_mem [NODES];
	logic [NW-1:0] tent_raddr, tent_waddr, tent_wp, tent_rp, chain_raddr, chain_rd;
	cost_t         tent_rc, tent_wc;
	logic          tent_we, chain_we;

	// edge store
	logic          e_we, e_on, clearing;
	logic [AW-1:0] e_waddr, e_raddr;
	logic [WEIGHT_BITS-1:0] e_w, e_ww;

	// relax unit
	cost_t ru_base, ru_ref, ru_sum;
	logic  ru_tie, ru_lt;

	logic  acc, src_ok, dst_ok, last_v;
	logic  vdone, upd, has, better_r, better_c, lastx;
	cost_t ec;
	logic [NW-1:0] ep;

	logic    strobe_q, found_q, last_q;
	node_field_t node_out_q;
	cost_t   cost_out_q;

	function automatic logic [AW-1:0] mat_addr(input logic [NW-1:0] r, input logic [NW-1:0] c);
		mat_addr = AW'(AW'(r) * AW'(NODES)) + AW'(c);
	endfunction

	assign busy   = clearing || (st_q != S_IDLE);
	assign acc    = start && !busy;
	assign src_ok = {2'b00, src_node} < 7'(NODES);
	assign dst_ok = {2'b00, dst_node} < 7'(NODES);
	assign last_v = v_s1 == NW'(NODES - 1);
	assign km1    = k_q - KW'(1);

	assign e_we    = acc && !action && src_ok && dst_ok;
	assign e_waddr = mat_addr(NW'(src_node), NW'(dst_node));
	assign e_ww    = edge_present ? WEIGHT_BITS'(edge_weight) : '0;
	assign e_raddr = (st_q == S_CYC) ? mat_addr(v_q, src_q) : mat_addr(cur_q, v_q);

	dgsp_edge_mem #(
		.NODES(NODES),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_edges (
		.clk(clk),
		.arst_n(arst_n),
		.we(e_we),
		.waddr(e_waddr),
		.won(edge_present),
		.ww(e_ww),
		.raddr(e_raddr),
		.ron(e_on),
		.rw(e_w),
		.clearing(clearing)
	);

	// Relax pass adds the edge to the settled cost; cycle scan adds it to the tail's cost.
	assign ru_base = (st_q == S_CYC) ? tent_rc : cur_cost_q;
	assign ru_ref  = (st_q == S_CYC) ? bc_q : tent_rc;
	assign ru_tie  = (st_q == S_CYC) ? 1'b0 : (cur_q < tent_rp);

	dgsp_relax_unit #(
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_relax (
		.base(ru_base),
		.w(e_w),
		.ref_c(ru_ref),
		.tie_lt(ru_tie),
		.sum(ru_sum),
		.lt(ru_lt)
	);

	always_comb begin
		vdone    = done_q[v_s1];
		upd      = !vdone && e_on && (!tval_q[v_s1] || ru_lt);
		has      = !vdone && (tval_q[v_s1] || upd);
		ec       = upd ? ru_sum : tent_rc;
		ep       = upd ? cur_q : tent_rp;
		better_r = has && (!have_q || (ec < bc_q) || ((ec == bc_q) && (ep < bp_q)));
		better_c = (v_s1 != src_q) && e_on && done_q[v_s1] && (!have_q || ru_lt);
		lastx    = (k_q == KW'(1)) || (n_q == 5'(MAX_OUT - 1));
	end

	// node table ports
	always_comb begin
		tent_we    = 1'b0;
		tent_waddr = v_s1;
		tent_wc    = ru_sum;
		tent_wp    = cur_q;
		if (st_q == S_INIT) begin
			tent_we    = 1'b1;
			tent_waddr = src_q;
			tent_wc    = '0;
			tent_wp    = src_q;
		end else if (st_q == S_RELAX && valid_s1 && upd) begin
			tent_we = 1'b1;
		end
		case (st_q)
			S_WALK:    tent_raddr = node_q;
			S_EMIT_RD: tent_raddr = chain_rd;
			default:   tent_raddr = v_q;
		endcase
		chain_we    = st_q == S_WALK;
		chain_raddr = km1[NW-1:0];
	end

	always_ff @(posedge clk) begin
		if (tent_we) begin
			cost_mem[tent_waddr] <= tent_wc;
			pred_mem[tent_waddr] <= tent_wp;
		end
		tent_rc <= cost_mem[tent_raddr];
		tent_rp <= pred_mem[tent_raddr];
	end

	always_ff @(posedge clk) begin
		if (chain_we) begin
			chain_mem[k_q[NW-1:0]] <= node_q;
		end
		chain_rd <= chain_mem[chain_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (st_q == S_RELAX || st_q == S_CYC) && !iss_done_q;
		end
	end

	always_ff @(posedge clk) begin
		v_s1 <= v_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			done_q     <= '0;
			tval_q     <= '0;
			have_q     <= 1'b0;
			iss_done_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= (st_q == S_EMIT_OUT) || (st_q == S_NF);
			case (st_q)
				S_IDLE: begin
					if (acc && action) begin
						src_q <= NW'(src_node);
						dst_q <= NW'(dst_node);
						cyc_q <= src_node == dst_node;
						st_q  <= (src_ok && dst_ok) ? S_INIT : S_NF;
					end
				end
				S_INIT: begin
					done_q         <= NODES'(1) << src_q;
					tval_q         <= '0;
					cur_q          <= src_q;
					cur_cost_q     <= '0;
					v_q            <= '0;
					iss_done_q     <= 1'b0;
					have_q         <= 1'b0;
					st_q           <= S_RELAX;
				end
				S_RELAX, S_CYC: begin
					if (!iss_done_q) begin
						v_q <= v_q + NW'(1);
						if (v_q == NW'(NODES - 1)) begin
							iss_done_q <= 1'b1;
						end
					end
					if (valid_s1) begin
						if (st_q == S_RELAX) begin
							if (upd) begin
								tval_q[v_s1] <= 1'b1;
							end
							if (better_r) begin
								have_q <= 1'b1;
								bc_q   <= ec;
								bp_q   <= ep;
								bv_q   <= v_s1;
							end
						end else if (better_c) begin
							have_q <= 1'b1;
							bc_q   <= ru_sum;
							bv_q   <= v_s1;
						end
						if (last_v) begin
							st_q <= (st_q == S_RELAX) ? S_PICK : S_CYC_END;
						end
					end
				end
				S_PICK: begin
					v_q        <= '0;
					iss_done_q <= 1'b0;
					have_q     <= 1'b0;
					if (!have_q) begin
						st_q <= cyc_q ? S_CYC : S_NF;
					end else begin
						done_q[bv_q] <= 1'b1;
						cur_q        <= bv_q;
						cur_cost_q   <= bc_q;
						if (!cyc_q && bv_q == dst_q) begin
							final_q <= bc_q;
							node_q  <= dst_q;
							k_q     <= '0;
							st_q    <= S_WALK;
						end else begin
							st_q <= S_RELAX;
						end
					end
				end
				S_CYC_END: begin
					if (!have_q) begin
						st_q <= S_NF;
					end else begin
						final_q <= bc_q;
						node_q  <= bv_q;
						k_q     <= '0;
						st_q    <= S_WALK;
					end
				end
				S_WALK: begin
					// Push the node; stop at the source or when the chain is full.
					k_q <= k_q + KW'(1);
					if (node_q == src_q || k_q == KW'(NODES - 1)) begin
						n_q  <= '0;
						st_q <= S_EMIT;
					end else begin
						st_q <= S_WALK_RD;
					end
				end
				S_WALK_RD: begin
					node_q <= tent_rp;
					st_q   <= S_WALK;
				end
				S_EMIT: begin
					st_q <= S_EMIT_RD;
				end
				S_EMIT_RD: begin
					nd_q <= chain_rd;
					st_q <= S_EMIT_OUT;
				end
				S_EMIT_OUT: begin
					node_out_q <= NODE_FIELD_W'(nd_q);
					cost_out_q <= lastx ? final_q : tent_rc;
					found_q    <= 1'b1;
					last_q     <= lastx;
					k_q        <= km1;
					n_q        <= n_q + 5'd1;
					st_q       <= lastx ? S_IDLE : S_EMIT;
				end
				S_NF: begin
					node_out_q <= '0;
					cost_out_q <= '0;
					found_q    <= 1'b0;
					last_q     <= 1'b1;
					st_q       <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign strobe    = strobe_q;
	assign path_node = node_out_q;
	assign path_cost = cost_out_q;
	assign found     = found_q;
	assign last      = last_q;

	`DGSP_CHECK(a_nf_single, strobe && !found |-> last && path_node == '0, "bad not-found result")
	`DGSP_CHECK(a_busy_clear, clearing |-> busy, "ready during clearing sweep")
	`DGSP_CHECK(a_settle, (st_q == S_PICK && have_q) |=> done_q[$past(bv_q)], "node not settled")
	`DGSP_CHECK(a_walk_len, st_q == S_WALK |-> k_q < KW'(NODES), "path chain overrun")

endmodule
